[rtl/core/ssls_pkg.sv]
// Shared types and constants of the sorted static list search block.
package ssls_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int KEY_WIDTH_DEFAULT   = 32;

   localparam int INDEX_W   = 10;
   localparam int KEY_IN_W  = 32;
   localparam int ENTRIES_W = 11;
   localparam int SLOT_EXT_W = 16;

   // sample counter: floor(sqrt(2047)) = 45 samples at most
   localparam int SAMPLE_W   = 6;
   localparam int SAMPLE_MAX = 45;

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_HEAD_INDEX   = 2'd0;
   localparam logic [1:0] REG_ENTRIES_USED = 2'd1;
   localparam logic [1:0] REG_SAMPLED_MODE = 2'd2;

   typedef struct packed {
      logic                       action;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [KEY_IN_W-1:0] entry_key;
      logic [INDEX_W-1:0]         entry_next;
      logic                       entry_is_last;
      logic signed [KEY_IN_W-1:0] search_key;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0]         result_index;
      logic                       not_found;
      logic signed [KEY_IN_W-1:0] result_key;
      logic                       is_write_ack;
   } rsp_item_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_SAMPLE,
      RD_CUR,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       load_item;
      logic       mem_write;
      logic       wr_ack;
      logic       set_head;
      logic       init_best;
      logic       sample_cmp;
      logic       walk_step;
      logic       walk_fin;
      logic       rsp_load;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic samp_more;
      logic walk_hit;
      logic walk_end;
   } status_type;

endpackage

[rtl/core/ssls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ssls_dp.sv]
// Datapath: list table, item and result registers, sample and walk arithmetic.
module ssls_dp #(
   parameter int TABLE_DEPTH = ssls_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH   = ssls_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ssls_pkg::cmd_type               cmd,
   output ssls_pkg::status_type            status,
   input  ssls_pkg::req_item_type          req_item,
   input  logic [ssls_pkg::INDEX_W-1:0]    head_index,
   input  logic [ssls_pkg::ENTRIES_W-1:0]  entries_used,
   output ssls_pkg::rsp_item_type          rsp_item
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int WORD_W = KEY_WIDTH + IDX_W + 1;
   localparam int SW     = ssls_pkg::SAMPLE_W;
   localparam int SQ_W   = 2 * SW + 2;
   localparam int EXT_W  = ssls_pkg::SLOT_EXT_W;

   function automatic logic [IDX_W-1:0] slot_of(input logic [EXT_W-1:0] v);
      return v[IDX_W-1:0];
   endfunction

   ssls_pkg::req_item_type item_ff, item_in;
   ssls_pkg::rsp_item_type res_ff, res_in, rsp_ff, rsp_in;

   logic [IDX_W-1:0]            cur_ff, cur_in, visits_ff, visits_in;
   logic [IDX_W-1:0]            rd_addr, rd_next, wr_addr;
   logic signed [KEY_WIDTH-1:0] best_ff, best_in, rd_key, srch_key, wr_key;
   logic [SW-1:0]               samp_ff, samp_in;
   logic [SW:0]                 samp_p1;
   logic [SQ_W-1:0]             samp_sq;
   logic                        rd_last;
   logic [WORD_W-1:0]           wr_data, rd_data;
   logic signed [31:0]          wr_key32, rd_key32;
   logic [EXT_W-1:0]            cur_ext;

   ssls_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.mem_write),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_key   = KEY_WIDTH'(item_ff.entry_key);
   assign srch_key = KEY_WIDTH'(item_ff.search_key);
   assign wr_key32 = 32'(wr_key);
   assign wr_addr  = slot_of(EXT_W'(item_ff.entry_index));
   assign wr_data  = {item_ff.entry_is_last, slot_of(EXT_W'(item_ff.entry_next)), wr_key};

   assign rd_key   = rd_data[KEY_WIDTH-1:0];
   assign rd_next  = rd_data[KEY_WIDTH +: IDX_W];
   assign rd_last  = rd_data[WORD_W-1];
   assign rd_key32 = 32'(rd_key);
   assign cur_ext  = EXT_W'(cur_ff);

   assign samp_p1 = (SW + 1)'(samp_ff) + 1'b1;
   assign samp_sq = SQ_W'(samp_p1) * SQ_W'(samp_p1);

   assign status.samp_more = samp_sq <= SQ_W'(entries_used);
   assign status.walk_hit  = rd_key >= srch_key;
   assign status.walk_end  = rd_last || (visits_ff == IDX_W'(TABLE_DEPTH - 1));

   always_comb begin
      case (cmd.rd_sel)
         ssls_pkg::RD_HEAD:   rd_addr = slot_of(EXT_W'(head_index));
         ssls_pkg::RD_SAMPLE: rd_addr = slot_of(EXT_W'(samp_ff));
         ssls_pkg::RD_CUR:    rd_addr = cur_ff;
         ssls_pkg::RD_NEXT:   rd_addr = rd_next;
         default:             rd_addr = cur_ff;
      endcase
   end

   always_comb begin
      item_in   = cmd.load_item ? req_item : item_ff;
      cur_in    = cur_ff;
      visits_in = visits_ff;
      samp_in   = samp_ff;
      best_in   = best_ff;
      res_in    = res_ff;
      rsp_in    = cmd.rsp_load ? res_ff : rsp_ff;
      if (cmd.set_head) begin
         cur_in    = slot_of(EXT_W'(head_index));
         visits_in = '0;
         samp_in   = '0;
      end
      if (cmd.init_best) begin
         best_in = rd_key;
      end
      if (cmd.sample_cmp) begin
         samp_in = samp_ff + 1'b1;
         if (rd_key > best_ff && rd_key <= srch_key) begin
            cur_in  = slot_of(EXT_W'(samp_ff));
            best_in = rd_key;
         end
      end
      if (cmd.walk_step) begin
         cur_in    = rd_next;
         visits_in = visits_ff + 1'b1;
      end
      if (cmd.wr_ack) begin
         res_in.result_index = item_ff.entry_index;
         res_in.not_found    = 1'b0;
         res_in.result_key   = wr_key32;
         res_in.is_write_ack = 1'b1;
      end
      if (cmd.walk_fin) begin
         res_in.is_write_ack = 1'b0;
         if (status.walk_hit) begin
            res_in.result_index = cur_ext[ssls_pkg::INDEX_W-1:0];
            res_in.not_found    = 1'b0;
            res_in.result_key   = rd_key32;
         end else begin
            res_in.result_index = '0;
            res_in.not_found    = 1'b1;
            res_in.result_key   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      cur_ff    <= cur_in;
      visits_ff <= visits_in;
      samp_ff   <= samp_in;
      best_ff   <= best_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_item = rsp_ff;

   a_step_only_when_open: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !status.walk_hit && !status.walk_end)
      else $error("walk advanced past a hit or the list end");

   a_sample_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sample_cmp |-> samp_ff < SW'(ssls_pkg::SAMPLE_MAX))
      else $error("sample index beyond sqrt bound");

   a_cmp_needs_more: assert property (@(posedge clock) disable iff (reset)
      cmd.sample_cmp |-> $past(status.samp_more))
      else $error("sample compared without a pending sample");

endmodule

[rtl/core/ssls_ctrl.sv]
// Controller: sequences writes, head read, sampling and list walk per item.
module ssls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_query,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 sampled_mode,
   input  ssls_pkg::status_type status,
   output ssls_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_HEAD,
      ST_BEST,
      ST_SRD,
      ST_SCMP,
      ST_WALK,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = ssls_pkg::RD_CUR;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = req_query ? ST_HEAD : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            cmd.wr_ack    = 1'b1;
            state_in      = ST_FIN;
         end
         ST_HEAD: begin
            cmd.set_head = 1'b1;
            cmd.rd_sel   = ssls_pkg::RD_HEAD;
            state_in     = sampled_mode ? ST_BEST : ST_WALK;
         end
         ST_BEST: begin
            cmd.init_best = 1'b1;
            state_in      = ST_SRD;
         end
         ST_SRD: begin
            if (status.samp_more) begin
               cmd.rd_sel = ssls_pkg::RD_SAMPLE;
               state_in   = ST_SCMP;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_SCMP: begin
            cmd.sample_cmp = 1'b1;
            state_in       = ST_SRD;
         end
         ST_WALK: begin
            if (status.walk_hit || status.walk_end) begin
               cmd.walk_fin = 1'b1;
               state_in     = ST_FIN;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.rd_sel    = ssls_pkg::RD_NEXT;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while an item is in flight");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result beat raised outside the finish step");

   a_write_path: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_query |=> state_ff == ST_WRITE)
      else $error("write beat did not enter the write step");

endmodule

[rtl/core/sorted_static_list_search.sv]
// Top level: register port, controller and datapath of the sorted list search.
// Per item: a write stores one entry; a plain query walks V entries from head_index, a sampled
// query first reads the head and S samples; V = entries visited (one table read each), S = floor(sqrt(entries_used)).
// One item in flight: the next request beat is taken in the cycle after the result is loaded;
// a waiting result beat stalls a finished item.
// Synchronous reset: idle, head_index 0, entries_used 1, sampled_mode 0; table undefined.
module sorted_static_list_search #(
   parameter int TABLE_DEPTH = ssls_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH   = ssls_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ssls_pkg::req_item_type         req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ssls_pkg::rsp_item_type         rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ssls_pkg::ADDR_W-1:0]    paddr,
   input  logic [ssls_pkg::DATA_W-1:0]    pwdata,
   output logic [ssls_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   logic [ssls_pkg::INDEX_W-1:0]   head_ff, head_in;
   logic [ssls_pkg::ENTRIES_W-1:0] entries_ff, entries_in;
   logic                           sampled_ff, sampled_in;
   logic                           csr_wr;

   ssls_pkg::cmd_type    cmd;
   ssls_pkg::status_type status;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      head_in    = head_ff;
      entries_in = entries_ff;
      sampled_in = sampled_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            ssls_pkg::REG_HEAD_INDEX:   head_in    = pwdata[ssls_pkg::INDEX_W-1:0];
            ssls_pkg::REG_ENTRIES_USED: entries_in = pwdata[ssls_pkg::ENTRIES_W-1:0];
            ssls_pkg::REG_SAMPLED_MODE: sampled_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         ssls_pkg::REG_HEAD_INDEX:   prdata = ssls_pkg::DATA_W'(head_ff);
         ssls_pkg::REG_ENTRIES_USED: prdata = ssls_pkg::DATA_W'(entries_ff);
         ssls_pkg::REG_SAMPLED_MODE: prdata = ssls_pkg::DATA_W'(sampled_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         entries_ff <= ssls_pkg::ENTRIES_W'(1);
         sampled_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         entries_ff <= entries_in;
         sampled_ff <= sampled_in;
      end
   end

   ssls_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_query    (req_item.action),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .sampled_mode (sampled_ff),
      .status       (status),
      .cmd          (cmd)
   );

   ssls_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_item     (req_item),
      .head_index   (head_ff),
      .entries_used (entries_ff),
      .rsp_item     (rsp_item)
   );

endmodule
